@@ rtl/core/triangle_plane_clipper_assert.svh @@
// Assertion macros shared by the triangle plane clipper checkers.
`ifndef TRIANGLE_PLANE_CLIPPER_ASSERT_SVH
`define TRIANGLE_PLANE_CLIPPER_ASSERT_SVH

// Concurrent check, quiet while reset is asserted.
`define TCP_ASSERT(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// Concurrent check that also holds during reset.
`define TCP_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

@@ rtl/core/tcp_pkg.sv @@
// Shared types and constants of the triangle plane clipper.
`timescale 1ns / 1ps

package tcp_pkg;

    localparam int COORD_W = 32;
    localparam int DIST_W  = 63;
    localparam int TDATA_W = 9 * COORD_W;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // quotient bits resolved by the crossing divider; larger quotients saturate
    localparam int QBITS     = 42;
    localparam int CROSS_LAT = QBITS + 6;
    localparam int OUT_DEPTH = 2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIST_W-1:0]  dist_t;

    typedef struct packed {
        coord_t z;
        coord_t y;
        coord_t x;
    } vert_t;

    typedef vert_t [2:0] tri_t;

    typedef struct packed {
        logic valid;
        logic sub;
    } slot_t;

    typedef struct packed {
        logic last;
        tri_t verts;
    } oq_t;

    localparam logic [2:0] REG_NORMAL_X  = 3'd0;
    localparam logic [2:0] REG_NORMAL_Y  = 3'd1;
    localparam logic [2:0] REG_NORMAL_Z  = 3'd2;
    localparam logic [2:0] REG_OFFSET    = 3'd3;
    localparam logic [2:0] REG_KEEP_POS  = 3'd4;
    localparam logic [2:0] REG_TOLERANCE = 3'd5;

    localparam coord_t      RST_NORMAL_X  = 32'sd0;
    localparam coord_t      RST_NORMAL_Y  = 32'sd0;
    localparam coord_t      RST_NORMAL_Z  = 32'sd1073741824;
    localparam coord_t      RST_OFFSET    = 32'sd0;
    localparam logic        RST_KEEP_POS  = 1'b1;
    localparam logic [31:0] RST_TOLERANCE = 32'd70369;

    localparam dist_t  DIST_MAX  = 63'sh3FFF_FFFF_FFFF_FFFF;
    localparam dist_t  DIST_MIN  = 63'sh4000_0000_0000_0000;
    localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
    localparam coord_t COORD_MIN = 32'sh8000_0000;
    localparam logic [40:0] DELTA_SAT = 41'h100_0000_0000;

endpackage

@@ rtl/core/tcp_delay.sv @@
// Enabled delay line that carries slot control and side data.
`timescale 1ns / 1ps

module tcp_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  tcp_pkg::slot_t      slot_in,
    input  logic [WIDTH-1:0]    data_in,
    output tcp_pkg::slot_t      slot_out,
    output logic [WIDTH-1:0]    data_out
);

    tcp_pkg::slot_t   slot_reg [DEPTH];
    logic [WIDTH-1:0] data_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                slot_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            slot_reg[0] <= slot_in;
            for (int i = 1; i < DEPTH; i++)
            begin
                slot_reg[i] <= slot_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg[0] <= data_in;
            for (int i = 1; i < DEPTH; i++)
            begin
                data_reg[i] <= data_reg[i-1];
            end
        end
    end

    assign slot_out = slot_reg[DEPTH-1];
    assign data_out = data_reg[DEPTH-1];

endmodule

@@ rtl/core/tcp_dist.sv @@
// Signed plane distance and keep test for three vertices, three stages.
`timescale 1ns / 1ps

module tcp_dist (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  tcp_pkg::slot_t          slot_in,
    input  tcp_pkg::tri_t           v_in,
    input  tcp_pkg::coord_t         normal_x,
    input  tcp_pkg::coord_t         normal_y,
    input  tcp_pkg::coord_t         normal_z,
    input  tcp_pkg::coord_t         offset_val,
    input  logic                    keep_pos,
    input  logic [31:0]             tol,
    output tcp_pkg::slot_t          slot_out,
    output tcp_pkg::tri_t           v_out,
    output tcp_pkg::dist_t [2:0]    d_out,
    output logic [2:0]              kept_out
);

    tcp_pkg::slot_t slot_m_reg, slot_s_reg, slot_k_reg;
    tcp_pkg::tri_t  v_m_reg, v_s_reg, v_k_reg;

    logic signed [63:0] prod_reg  [3][3];
    logic signed [63:0] prod_next [3][3];
    tcp_pkg::dist_t     d_s_reg   [3];
    tcp_pkg::dist_t     d_s_next  [3];
    tcp_pkg::dist_t     d_k_reg   [3];
    logic [2:0]         kept_reg, kept_next;

    logic signed [61:0] off_term;
    logic signed [63:0] tol64;

    assign off_term = {offset_val, 30'b0};
    assign tol64    = signed'({32'b0, tol});

    // multiply each coordinate by its normal component
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_next[i][0] = v_in[i].x * normal_x;
            prod_next[i][1] = v_in[i].y * normal_y;
            prod_next[i][2] = v_in[i].z * normal_z;
        end
    end

    // sum, remove offset, saturate to the distance range
    always_comb
    begin
        logic signed [65:0] acc;
        for (int i = 0; i < 3; i++)
        begin
            acc = 66'(prod_reg[i][0]) + 66'(prod_reg[i][1]) + 66'(prod_reg[i][2])
                - 66'(off_term);
            if (acc[65:62] == 4'b0000 || acc[65:62] == 4'b1111)
            begin
                d_s_next[i] = acc[62:0];
            end
            else
            begin
                d_s_next[i] = acc[65] ? tcp_pkg::DIST_MIN : tcp_pkg::DIST_MAX;
            end
        end
    end

    always_comb
    begin
        logic signed [63:0] d64;
        for (int i = 0; i < 3; i++)
        begin
            d64 = 64'(d_s_reg[i]);
            kept_next[i] = keep_pos ? (d64 >= -tol64) : (d64 <= tol64);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_m_reg <= '0;
            slot_s_reg <= '0;
            slot_k_reg <= '0;
        end
        else if (en)
        begin
            slot_m_reg <= slot_in;
            slot_s_reg <= slot_m_reg;
            slot_k_reg <= slot_s_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_m_reg  <= v_in;
            v_s_reg  <= v_m_reg;
            v_k_reg  <= v_s_reg;
            prod_reg <= prod_next;
            d_s_reg  <= d_s_next;
            d_k_reg  <= d_s_reg;
            kept_reg <= kept_next;
        end
    end

    assign slot_out = slot_k_reg;
    assign v_out    = v_k_reg;
    assign kept_out = kept_reg;
    assign d_out    = {d_k_reg[2], d_k_reg[1], d_k_reg[0]};

endmodule

@@ rtl/core/tcp_cross.sv @@
// One coordinate of an edge crossing point: multiply, bit-serial divide, round.
`timescale 1ns / 1ps

module tcp_cross (
    input  logic            clk,
    input  logic            en,
    input  tcp_pkg::coord_t c,
    input  tcp_pkg::coord_t n,
    input  tcp_pkg::dist_t  dc,
    input  tcp_pkg::dist_t  dn,
    output tcp_pkg::coord_t r
);

    localparam int QB = tcp_pkg::QBITS;

    typedef struct packed {
        logic [63:0]     den;
        logic [63:0]     rem;
        logic [QB-1:0]   nl;
        logic [QB-1:0]   q;
        tcp_pkg::coord_t c;
        logic            neg;
        logic            dz;
        logic            ovf;
    } dstage_t;

    // operand preparation
    logic signed [32:0] diff;
    logic signed [63:0] den;
    logic [32:0]        diff_abs;
    logic [62:0]        dc_abs;

    logic [31:0]     dmag_reg;
    logic [62:0]     dcm_reg;
    logic [63:0]     denm_c0_reg, denm_c1_reg, denm_c2_reg;
    tcp_pkg::coord_t c_c0_reg, c_c1_reg, c_c2_reg;
    logic            neg_c0_reg, neg_c1_reg, neg_c2_reg;
    logic            dz_c0_reg, dz_c1_reg, dz_c2_reg;

    logic [63:0] pl_reg;
    logic [62:0] ph_reg;
    logic [94:0] num_reg;

    dstage_t st_reg [QB+1];
    dstage_t st0_next;

    logic [40:0]     mag_reg;
    tcp_pkg::coord_t c_r_reg;
    logic            neg_r_reg, dz_r_reg;
    tcp_pkg::coord_t r_reg;

    assign diff     = 33'(n) - 33'(c);
    assign den      = 64'(dc) - 64'(dn);
    assign diff_abs = diff[32] ? 33'(-diff) : 33'(diff);
    assign dc_abs   = dc[62] ? (~dc + 63'd1) : dc;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dmag_reg    <= diff_abs[31:0];
            dcm_reg     <= dc_abs;
            denm_c0_reg <= den[63] ? (~den + 64'd1) : den;
            c_c0_reg    <= c;
            neg_c0_reg  <= diff[32] ^ dc[62] ^ den[63];
            dz_c0_reg   <= (den == 64'sd0);

            pl_reg      <= dmag_reg * dcm_reg[31:0];
            ph_reg      <= dmag_reg * dcm_reg[62:32];
            denm_c1_reg <= denm_c0_reg;
            c_c1_reg    <= c_c0_reg;
            neg_c1_reg  <= neg_c0_reg;
            dz_c1_reg   <= dz_c0_reg;

            num_reg     <= {31'b0, pl_reg} + {ph_reg, 32'b0};
            denm_c2_reg <= denm_c1_reg;
            c_c2_reg    <= c_c1_reg;
            neg_c2_reg  <= neg_c1_reg;
            dz_c2_reg   <= dz_c1_reg;
        end
    end

    // flag quotients that cannot fit, seed the remainder with the high bits
    always_comb
    begin
        st0_next.den = denm_c2_reg;
        st0_next.rem = 64'(num_reg[94:QB]);
        st0_next.nl  = num_reg[QB-1:0];
        st0_next.q   = '0;
        st0_next.c   = c_c2_reg;
        st0_next.neg = neg_c2_reg;
        st0_next.dz  = dz_c2_reg;
        st0_next.ovf = {11'b0, num_reg} >= {denm_c2_reg, {QB{1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= st0_next;
        end
    end

    // one quotient bit per stage
    for (genvar s = 0; s < QB; s++)
    begin : g_step
        logic [64:0] t;
        logic [64:0] t_sub;
        logic        ge;
        dstage_t     st_next;

        assign t     = {st_reg[s].rem, st_reg[s].nl[QB-1]};
        assign t_sub = t - {1'b0, st_reg[s].den};
        assign ge    = (t >= {1'b0, st_reg[s].den});

        always_comb
        begin
            st_next     = st_reg[s];
            st_next.rem = ge ? t_sub[63:0] : t[63:0];
            st_next.nl  = {st_reg[s].nl[QB-2:0], 1'b0};
            st_next.q   = {st_reg[s].q[QB-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[s+1] <= st_next;
            end
        end
    end

    // round to nearest, ties up, then clamp the magnitude
    logic        rnd;
    logic [42:0] qr;
    logic [40:0] mag_next;

    assign rnd      = ({st_reg[QB].rem, 1'b0} >= {1'b0, st_reg[QB].den});
    assign qr       = {1'b0, st_reg[QB].q} + 43'(rnd);
    assign mag_next = (st_reg[QB].ovf || qr > 43'(tcp_pkg::DELTA_SAT))
                    ? tcp_pkg::DELTA_SAT : qr[40:0];

    // apply sign, add to the start vertex, clamp to 32 bits
    logic signed [42:0] smag;
    logic signed [42:0] sum;
    tcp_pkg::coord_t    r_next;

    assign smag = neg_r_reg ? -$signed({2'b0, mag_reg}) : $signed({2'b0, mag_reg});
    assign sum  = 43'(c_r_reg) + smag;

    always_comb
    begin
        if (dz_r_reg)
        begin
            r_next = c_r_reg;
        end
        else if (sum > 43'(tcp_pkg::COORD_MAX))
        begin
            r_next = tcp_pkg::COORD_MAX;
        end
        else if (sum < 43'(tcp_pkg::COORD_MIN))
        begin
            r_next = tcp_pkg::COORD_MIN;
        end
        else
        begin
            r_next = sum[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg   <= mag_next;
            c_r_reg   <= st_reg[QB].c;
            neg_r_reg <= st_reg[QB].neg;
            dz_r_reg  <= st_reg[QB].dz;
            r_reg     <= r_next;
        end
    end

    assign r = r_reg;

endmodule

@@ rtl/core/triangle_plane_clipper.sv @@
// Top level of the triangle plane clipper: config port, slot pipeline, output queue.
//
// Usage: one triangle (nine Q16.16 coordinates) is offered on the s_ stream
// and clipped against the plane n.p = offset held in the APB registers.
// Each accepted triangle yields zero, one or two triangles on the m_ stream;
// m_tlast marks the final one of an input. A triangle fully on the dropped
// side yields nothing.
// Throughput: no input is taken while the last one is in its first slot,
// and none while the output queue is full. Each input occupies two pipeline
// slots, one per edge crossing, and the two crossings share three coordinate
// dividers (one quotient bit per stage).
// Path from input transfer to the first output transfer: input register and
// the second slot behind it, 3 distance stages, 48 crossing stages and the output queue.
// Reset: clears the pipeline valid bits, the queue and the registers to
// their documented defaults; no clearing pass is needed.
// Stall: the whole pipeline advances only while the output queue has room,
// so no input is accepted while the queue is full and waits on m_tready.
// Write the registers only while no triangle is in flight.
`timescale 1ns / 1ps

module triangle_plane_clipper #(
    parameter int OUT_DEPTH = tcp_pkg::OUT_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // in_v0_x, in_v0_y, in_v0_z, in_v1_x .. in_v2_z, 32 bits each, from bit 0
    input  logic [tcp_pkg::TDATA_W-1:0]   s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // out_v0_x, out_v0_y, out_v0_z, out_v1_x .. out_v2_z, 32 bits each, from bit 0
    output logic [tcp_pkg::TDATA_W-1:0]   m_tdata,
    output logic                          m_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcp_pkg::ADDR_W-1:0]    paddr,
    input  logic [tcp_pkg::DATA_W-1:0]    pwdata,
    output logic [tcp_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    localparam int PW = $clog2(OUT_DEPTH);
    localparam int CW = $clog2(OUT_DEPTH + 1);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    tcp_pkg::coord_t normal_x_reg, normal_y_reg, normal_z_reg, offset_reg;
    logic            keep_pos_reg;
    logic [31:0]     tol_reg;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_x_reg <= tcp_pkg::RST_NORMAL_X;
            normal_y_reg <= tcp_pkg::RST_NORMAL_Y;
            normal_z_reg <= tcp_pkg::RST_NORMAL_Z;
            offset_reg   <= tcp_pkg::RST_OFFSET;
            keep_pos_reg <= tcp_pkg::RST_KEEP_POS;
            tol_reg      <= tcp_pkg::RST_TOLERANCE;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                tcp_pkg::REG_NORMAL_X:  normal_x_reg <= pwdata;
                tcp_pkg::REG_NORMAL_Y:  normal_y_reg <= pwdata;
                tcp_pkg::REG_NORMAL_Z:  normal_z_reg <= pwdata;
                tcp_pkg::REG_OFFSET:    offset_reg   <= pwdata;
                tcp_pkg::REG_KEEP_POS:  keep_pos_reg <= pwdata[0];
                tcp_pkg::REG_TOLERANCE: tol_reg      <= pwdata;
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            tcp_pkg::REG_NORMAL_X:  prdata = normal_x_reg;
            tcp_pkg::REG_NORMAL_Y:  prdata = normal_y_reg;
            tcp_pkg::REG_NORMAL_Z:  prdata = normal_z_reg;
            tcp_pkg::REG_OFFSET:    prdata = offset_reg;
            tcp_pkg::REG_KEEP_POS:  prdata = {31'b0, keep_pos_reg};
            tcp_pkg::REG_TOLERANCE: prdata = tol_reg;
            default:                prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Pipeline enable: advance while the output queue has room
    // ---------------------------------------------------------------
    logic          en;
    logic [CW-1:0] oq_count_reg;

    assign en = (oq_count_reg != CW'(OUT_DEPTH));

    // ---------------------------------------------------------------
    // Input register: hold each triangle for two slots
    // ---------------------------------------------------------------
    tcp_pkg::slot_t s0_slot_reg;
    tcp_pkg::tri_t  s0_v_reg;

    assign s_tready = en && (!s0_slot_reg.valid || s0_slot_reg.sub);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_slot_reg <= '0;
        end
        else if (en)
        begin
            if (s0_slot_reg.valid && !s0_slot_reg.sub)
            begin
                s0_slot_reg.sub <= 1'b1;
            end
            else
            begin
                s0_slot_reg.valid <= s_tvalid;
                s0_slot_reg.sub   <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s0_v_reg <= s_tdata;
        end
    end

    // ---------------------------------------------------------------
    // Distances and keep flags
    // ---------------------------------------------------------------
    tcp_pkg::slot_t         dk_slot;
    tcp_pkg::tri_t          dk_v;
    tcp_pkg::dist_t [2:0]   dk_d;
    logic [2:0]             dk_kept;

    tcp_dist u_dist (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .slot_in      (s0_slot_reg),
        .v_in         (s0_v_reg),
        .normal_x     (normal_x_reg),
        .normal_y     (normal_y_reg),
        .normal_z     (normal_z_reg),
        .offset_val   (offset_reg),
        .keep_pos     (keep_pos_reg),
        .tol          (tol_reg),
        .slot_out     (dk_slot),
        .v_out        (dk_v),
        .d_out        (dk_d),
        .kept_out     (dk_kept)
    );

    // ---------------------------------------------------------------
    // Edge pick: first slot takes the first crossing edge in walk order,
    // second slot the last one
    // ---------------------------------------------------------------
    logic [2:0]      cross_edge;
    logic [1:0]      edge_a, edge_b, edge_sel, edge_nxt;
    tcp_pkg::vert_t  c_vert, n_vert;

    assign cross_edge[0] = dk_kept[0] ^ dk_kept[1];
    assign cross_edge[1] = dk_kept[1] ^ dk_kept[2];
    assign cross_edge[2] = dk_kept[2] ^ dk_kept[0];

    assign edge_a   = cross_edge[0] ? 2'd0 : (cross_edge[1] ? 2'd1 : 2'd2);
    assign edge_b   = cross_edge[2] ? 2'd2 : (cross_edge[1] ? 2'd1 : 2'd0);
    assign edge_sel = dk_slot.sub ? edge_b : edge_a;
    assign edge_nxt = (edge_sel == 2'd2) ? 2'd0 : edge_sel + 2'd1;
    assign c_vert   = dk_v[edge_sel];
    assign n_vert   = dk_v[edge_nxt];

    tcp_pkg::coord_t r_x, r_y, r_z;

    tcp_cross u_cross_x (
        .clk (clk), .en (en), .c (c_vert.x), .n (n_vert.x),
        .dc (dk_d[edge_sel]), .dn (dk_d[edge_nxt]), .r (r_x)
    );

    tcp_cross u_cross_y (
        .clk (clk), .en (en), .c (c_vert.y), .n (n_vert.y),
        .dc (dk_d[edge_sel]), .dn (dk_d[edge_nxt]), .r (r_y)
    );

    tcp_cross u_cross_z (
        .clk (clk), .en (en), .c (c_vert.z), .n (n_vert.z),
        .dc (dk_d[edge_sel]), .dn (dk_d[edge_nxt]), .r (r_z)
    );

    // carry the triangle and keep flags alongside the dividers
    localparam int META_W = $bits(tcp_pkg::tri_t) + 3;

    tcp_pkg::slot_t    md_slot;
    logic [META_W-1:0] md_data;
    tcp_pkg::tri_t     md_v;
    logic [2:0]        md_kept;

    tcp_delay #(
        .WIDTH (META_W),
        .DEPTH (tcp_pkg::CROSS_LAT)
    ) u_meta (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .slot_in  (dk_slot),
        .data_in  ({dk_kept, dk_v}),
        .slot_out (md_slot),
        .data_out (md_data)
    );

    assign md_v    = md_data[META_W-4:0];
    assign md_kept = md_data[META_W-1:META_W-3];

    // ---------------------------------------------------------------
    // Polygon assembly: first slot parks its crossing, second slot builds
    // the polygon and fans it
    // ---------------------------------------------------------------
    tcp_pkg::vert_t x_reg;
    tcp_pkg::vert_t y_vert;
    tcp_pkg::vert_t poly [4];
    logic [2:0]     cnt;

    assign y_vert = {r_z, r_y, r_x};

    always_ff @(posedge clk)
    begin
        if (en && md_slot.valid && !md_slot.sub)
        begin
            x_reg <= y_vert;
        end
    end

    always_comb
    begin
        logic xi;
        int   nx;
        for (int p = 0; p < 4; p++)
        begin
            poly[p] = '0;
        end
        cnt = 3'd0;
        xi  = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            nx = (i == 2) ? 0 : i + 1;
            if (md_kept[i] && md_kept[nx])
            begin
                poly[cnt[1:0]] = md_v[nx];
                cnt = cnt + 3'd1;
            end
            else if (md_kept[i] || md_kept[nx])
            begin
                poly[cnt[1:0]] = xi ? y_vert : x_reg;
                xi  = 1'b1;
                cnt = cnt + 3'd1;
                if (md_kept[nx])
                begin
                    poly[cnt[1:0]] = md_v[nx];
                    cnt = cnt + 3'd1;
                end
            end
        end
    end

    logic          slotb;
    logic          push;
    tcp_pkg::oq_t  first_tri, second_tri, push_data;
    tcp_pkg::oq_t  pend_reg;
    logic          pend_valid_reg;

    assign slotb      = md_slot.valid && md_slot.sub;
    assign first_tri  = {(cnt == 3'd3), poly[2], poly[1], poly[0]};
    assign second_tri = {1'b1, poly[3], poly[2], poly[0]};
    assign push       = en && (pend_valid_reg || (slotb && cnt >= 3'd3));
    assign push_data  = pend_valid_reg ? pend_reg : first_tri;

    // the second triangle goes out in the next advancing cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            pend_valid_reg <= slotb && (cnt == 3'd4);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && slotb)
        begin
            pend_reg <= second_tri;
        end
    end

    // ---------------------------------------------------------------
    // Output queue
    // ---------------------------------------------------------------
    tcp_pkg::oq_t  oq_mem_reg [OUT_DEPTH];
    logic [PW-1:0] oq_wr_reg, oq_rd_reg;
    logic          pop;
    tcp_pkg::oq_t  head;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (oq_count_reg != '0);
    assign head     = oq_mem_reg[oq_rd_reg];
    assign m_tdata  = head.verts;
    assign m_tlast  = head.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg    <= '0;
            oq_rd_reg    <= '0;
            oq_count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                oq_wr_reg <= (oq_wr_reg == PW'(OUT_DEPTH - 1)) ? '0 : oq_wr_reg + 1'b1;
            end
            if (pop)
            begin
                oq_rd_reg <= (oq_rd_reg == PW'(OUT_DEPTH - 1)) ? '0 : oq_rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                oq_count_reg <= oq_count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                oq_count_reg <= oq_count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            oq_mem_reg[oq_wr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/core/tcp_checker.sv @@
// Port-level checks of the triangle plane clipper and their bind.
`timescale 1ns / 1ps
`include "triangle_plane_clipper_assert.svh"

module tcp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tlast,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [tcp_pkg::ADDR_W-1:0]    paddr,
    input logic [tcp_pkg::DATA_W-1:0]    pwdata,
    input logic [tcp_pkg::DATA_W-1:0]    prdata,
    input logic                          pready
);

    logic in_xfer;
    logic out_xfer;
    logic out_wait;
    logic wr_nx;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;
    assign out_wait = m_tvalid && !m_tready;
    assign wr_nx    = psel && penable && pwrite && (paddr[4:2] == tcp_pkg::REG_NORMAL_X);

    // a stalled result stays offered
    `TCP_ASSERT(a_out_hold, clk, rst_n, out_wait |=> m_tvalid, "output valid dropped")

    // each triangle takes two slots, so no input transfer right after another
    `TCP_ASSERT(a_in_rate, clk, rst_n, in_xfer |=> !s_tready, "input taken twice in a row")

    // the second triangle of a pair is ready at once and closes the pair
    `TCP_ASSERT(a_pair, clk, rst_n, out_xfer && !m_tlast |=> m_tvalid && m_tlast, "pair split")

    // a written normal x reads back
    `TCP_ASSERT(a_readback, clk, rst_n, wr_nx |=> prdata == $past(pwdata), "readback mismatch")

    `TCP_ASSERT_ALWAYS(a_pready, clk, pready, "pready low")

endmodule

bind triangle_plane_clipper tcp_checker u_tcp_checker (.*);
